// File: rtl/bpdd_pkg.sv
package bpdd_pkg;

    // Framing and button characters.
    localparam logic [7:0] CH_START = 8'h21;
    localparam logic [7:0] CH_TYPE  = 8'h42;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    // Speed buttons and arrow buttons.
    localparam logic [7:0] BTN_SPEED_LO = 8'h31;
    localparam logic [7:0] BTN_SPEED_HI = 8'h34;
    localparam logic [7:0] BTN_UP       = 8'h35;
    localparam logic [7:0] BTN_DOWN     = 8'h36;
    localparam logic [7:0] BTN_LEFT     = 8'h37;
    localparam logic [7:0] BTN_RIGHT    = 8'h38;

    localparam logic [2:0] SPEED_RESET = 3'd4;

    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 24;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_TYPE   = 5'b00010,
        PH_BUTTON = 5'b00100,
        PH_HIT    = 5'b01000,
        PH_CHECK  = 5'b10000
    } phase_t;

    // A complete, checksum-correct packet as seen by the drive logic.
    typedef struct packed {
        logic       valid;
        logic [7:0] button;
        logic       pressed;
    } pkt_t;

endpackage

// File: rtl/bpdd_parser.sv
module bpdd_parser import bpdd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] rx_byte,
    output pkt_t       pkt
);

    phase_t     phase_reg, phase_next;
    logic [7:0] button_reg, button_next;
    logic [7:0] hit_reg, hit_next;
    logic [7:0] sum;

    // The checksum byte must equal the inverse of the eight-bit sum of the first four bytes.
    assign sum = CH_START + CH_TYPE + button_reg + hit_reg;

    always_comb begin
        phase_next  = phase_reg;
        button_next = button_reg;
        hit_next    = hit_reg;
        pkt.valid   = 1'b0;
        pkt.button  = button_reg;
        pkt.pressed = (hit_reg == CH_ONE);
        unique case (phase_reg)
            PH_TYPE: begin
                phase_next = (rx_byte == CH_TYPE) ? PH_BUTTON : PH_IDLE;
            end
            PH_BUTTON: begin
                button_next = rx_byte;
                phase_next  = PH_HIT;
            end
            PH_HIT: begin
                hit_next   = rx_byte;
                phase_next = PH_CHECK;
            end
            PH_CHECK: begin
                phase_next = PH_IDLE;
                pkt.valid  = (rx_byte == ~sum);
            end
            default: begin
                phase_next = (rx_byte == CH_START) ? PH_TYPE : PH_IDLE;
            end
        endcase
        if (!step) begin
            pkt.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            button_reg <= '0;
            hit_reg    <= '0;
        end else if (step) begin
            phase_reg  <= phase_next;
            button_reg <= button_next;
            hit_reg    <= hit_next;
        end
    end

endmodule

// File: rtl/bpdd_drive.sv
module bpdd_drive import bpdd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  pkt_t              pkt,
    output logic signed [3:0] left_next,
    output logic signed [3:0] right_next
);

    logic [2:0]        speed_reg, speed_next;
    logic signed [3:0] left_reg, right_reg;
    logic signed [3:0] pos, neg;

    assign pos = signed'({1'b0, speed_reg});
    assign neg = -pos;

    always_comb begin
        speed_next = speed_reg;
        left_next  = left_reg;
        right_next = right_reg;
        if (pkt.valid) begin
            if (pkt.button >= BTN_SPEED_LO && pkt.button <= BTN_SPEED_HI) begin
                if (pkt.pressed) begin
                    speed_next = pkt.button[2:0];
                end
            end else if (pkt.button >= BTN_UP && pkt.button <= BTN_RIGHT) begin
                if (!pkt.pressed) begin
                    left_next  = '0;
                    right_next = '0;
                end else begin
                    unique case (pkt.button)
                        BTN_UP: begin
                            left_next  = pos;
                            right_next = pos;
                        end
                        BTN_DOWN: begin
                            left_next  = neg;
                            right_next = neg;
                        end
                        BTN_LEFT: begin
                            left_next  = neg;
                            right_next = pos;
                        end
                        default: begin
                            left_next  = pos;
                            right_next = neg;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_reg <= SPEED_RESET;
            left_reg  <= '0;
            right_reg <= '0;
        end else begin
            speed_reg <= speed_next;
            left_reg  <= left_next;
            right_reg <= right_next;
        end
    end

endmodule

// File: rtl/button_packet_drive_decoder_core.sv
// Button packet decoder for a two-motor drive.
// The slave channel takes one received serial byte per item. The parser looks for the
// five-byte packet '!', 'B', button, hit, checksum, where the checksum is the inverse of
// the eight-bit sum of the first four bytes. A bad header or checksum byte sends the
// parser back to hunting for '!', and that byte is not looked at again as a start byte.
// Each good packet gives one item on the master channel: the raw button byte, the pressed
// flag, the LED nibble and the left and right motor commands in quarters of full speed.
// Bytes that do not complete a good packet give no item.
// Each byte goes into an input register, is parsed by a single pass of combinational
// logic and, if it completes a packet, lands in the output register. The result item is
// therefore offered once the checksum byte has passed from the input register into the
// output register; one byte can be accepted in every cycle while the receiver does not
// stall. When the receiver stalls, the output register holds its item and the input
// register still takes one more byte; after that s_tready falls.
// Reset clears the parser to idle, the motor commands to zero and the speed to full,
// and empties both registers.
module button_packet_drive_decoder_core import bpdd_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,  // [7:0] rx_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [7:0] button_code, [8] pressed, [12:9] led_pattern, [16:13] left_drive,
    // [20:17] right_drive, [23:21] zero
    output logic [TDATA_OUT_W-1:0] m_tdata
);

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   out_valid_reg;
    logic [TDATA_OUT_W-1:0] out_data_reg;
    logic [TDATA_OUT_W-1:0] out_data_next;
    logic                   step;
    pkt_t                   pkt;
    logic signed [3:0]      left_next, right_next;

    // The held byte moves on once the output register is free or being emptied.
    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    bpdd_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .rx_byte (in_byte_reg),
        .pkt     (pkt)
    );

    bpdd_drive u_drive (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pkt        (pkt),
        .left_next  (left_next),
        .right_next (right_next)
    );

    // The LED nibble is the button byte less '0'; its low four bits are the button's own.
    assign out_data_next = {3'b000, right_next, left_next, pkt.button[3:0],
                            pkt.pressed, pkt.button};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (step) begin
                out_valid_reg <= pkt.valid;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (pkt.valid) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bpdd_pkg::*;

    // One decoded packet as it leaves the block, laid out field for field like m_tdata,
    // but with the first field in the most significant bits of the struct.
    typedef struct packed {
        logic [7:0]        button_code;
        logic              pressed;
        logic [3:0]        led_pattern;
        logic signed [3:0] left_drive;
        logic signed [3:0] right_drive;
    } drive_report_t;

    // One row of the directed table: the byte to send and, where the outcome is plain to
    // see, the report that the packet closed by this byte must produce.
    typedef struct packed {
        logic [7:0]    rx_byte;
        logic          typed;
        drive_report_t want;
    } stim_row_t;

    localparam drive_report_t NO_REPORT = '0;
    localparam int DIRECTED_N = 27;
    localparam int RANDOM_ITEMS = 1550;
    localparam int QUIET_TAIL = 200;

    // The directed part: a full-speed forward press, a start byte sent three times, whose
    // second copy must not restart the packet, a speed change to one quarter, a left turn
    // at that speed, a packet with a bad checksum (extreme button and hit bytes), and a
    // released arrow with an all-ones hit byte, which stops both motors.
    stim_row_t directed_rows [DIRECTED_N] = '{
        {8'h21, 1'b0, NO_REPORT},
        {8'h42, 1'b0, NO_REPORT},
        {8'h35, 1'b0, NO_REPORT},
        {8'h31, 1'b0, NO_REPORT},
        {8'h36, 1'b1, 8'h35, 1'b1, 4'h5, 4'h4, 4'h4},
        {8'h21, 1'b0, NO_REPORT},
        {8'h21, 1'b0, NO_REPORT},
        {8'h21, 1'b0, NO_REPORT},
        {8'h42, 1'b0, NO_REPORT},
        {8'h31, 1'b0, NO_REPORT},
        {8'h31, 1'b0, NO_REPORT},
        {8'h3A, 1'b1, 8'h31, 1'b1, 4'h1, 4'h4, 4'h4},
        {8'h21, 1'b0, NO_REPORT},
        {8'h42, 1'b0, NO_REPORT},
        {8'h37, 1'b0, NO_REPORT},
        {8'h31, 1'b0, NO_REPORT},
        {8'h34, 1'b1, 8'h37, 1'b1, 4'h7, 4'hF, 4'h1},
        {8'h21, 1'b0, NO_REPORT},
        {8'h42, 1'b0, NO_REPORT},
        {8'hFF, 1'b0, NO_REPORT},
        {8'h00, 1'b0, NO_REPORT},
        {8'h00, 1'b0, NO_REPORT},
        {8'h21, 1'b0, NO_REPORT},
        {8'h42, 1'b0, NO_REPORT},
        {8'h36, 1'b0, NO_REPORT},
        {8'hFF, 1'b0, NO_REPORT},
        {8'h67, 1'b1, 8'h36, 1'b0, 4'h6, 4'h0, 4'h0}
    };

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata = '0;   // [7:0] rx_byte
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // [7:0] button_code, [8] pressed, [12:9] led_pattern, [16:13] left_drive,
    // [20:17] right_drive, [23:21] zero
    logic [TDATA_OUT_W-1:0] m_tdata;

    // Our own copy of the decoder's state, advanced once for every accepted byte.
    phase_t            parse_phase;
    logic [7:0]        held_button;
    logic [7:0]        held_hit;
    logic [2:0]        speed_step;
    logic signed [3:0] left_cmd;
    logic signed [3:0] right_cmd;

    // Reports that accepted packets have earned and that the block has yet to deliver.
    drive_report_t drive_reports_due [$];

    int mismatch_count = 0;
    int bytes_sent = 0;
    int s_gap_pct = 0;
    int m_stall_pct = 0;

    button_packet_drive_decoder_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 aclk = ~aclk;

    // Advances the parser by one received byte. It returns 1 when the byte closes a
    // packet with a good checksum, and then rep holds the report the block must give.
    function automatic bit decode_rx_byte(input logic [7:0] rx, output drive_report_t rep);
        logic [7:0]        sum;
        logic              hit;
        logic signed [3:0] spd;
        rep = NO_REPORT;
        case (parse_phase)
            PH_TYPE: begin
                parse_phase = (rx == CH_TYPE) ? PH_BUTTON : PH_IDLE;
                return 1'b0;
            end
            PH_BUTTON: begin
                held_button = rx;
                parse_phase = PH_HIT;
                return 1'b0;
            end
            PH_HIT: begin
                held_hit = rx;
                parse_phase = PH_CHECK;
                return 1'b0;
            end
            PH_CHECK: begin
                parse_phase = PH_IDLE;
            end
            default: begin
                // A byte that breaks the header lands here only on the next byte, so
                // the breaking byte itself is never taken as a fresh start.
                parse_phase = (rx == CH_START) ? PH_TYPE : PH_IDLE;
                return 1'b0;
            end
        endcase

        sum = CH_START + CH_TYPE + held_button + held_hit;
        if (rx != ~sum)
            return 1'b0;

        hit = (held_hit == CH_ONE);
        spd = $signed({1'b0, speed_step});
        if (held_button >= BTN_SPEED_LO && held_button <= BTN_SPEED_HI) begin
            if (hit)
                speed_step = 3'(held_button - CH_ZERO);
        end else if (held_button >= BTN_UP && held_button <= BTN_RIGHT) begin
            if (!hit) begin
                left_cmd  = '0;
                right_cmd = '0;
            end else begin
                case (held_button)
                    BTN_UP: begin
                        left_cmd  = spd;
                        right_cmd = spd;
                    end
                    BTN_DOWN: begin
                        left_cmd  = -spd;
                        right_cmd = -spd;
                    end
                    BTN_LEFT: begin
                        left_cmd  = -spd;
                        right_cmd = spd;
                    end
                    default: begin
                        left_cmd  = spd;
                        right_cmd = -spd;
                    end
                endcase
            end
        end

        rep.button_code = held_button;
        rep.pressed     = hit;
        rep.led_pattern = 4'(held_button - CH_ZERO);
        rep.left_drive  = left_cmd;
        rep.right_drive = right_cmd;
        return 1'b1;
    endfunction

    // Offers one byte on the slave channel, perhaps after a short gap, and waits for it
    // to be taken. Called and left at a rising edge. A typed row overrides the report
    // that the parser model works out.
    task automatic push_byte(input logic [7:0] rx, input bit typed, input drive_report_t want);
        drive_report_t rep;
        bit            done;
        if (s_gap_pct != 0 && $urandom_range(0, 99) < s_gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rx;
        // Handshake signals are settled by the falling edge, and nothing we drive
        // changes before the next rising edge, at which the item is taken.
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        done = decode_rx_byte(rx, rep);
        if (typed)
            drive_reports_due.push_back(want);
        else if (done)
            drive_reports_due.push_back(rep);
        bytes_sent++;
    endtask

    // One unit of random traffic. Most units are whole packets with random content, so
    // that the drive logic is reached often; the rest are broken headers, packets cut
    // short and stray bytes.
    task automatic push_random_unit();
        logic [7:0] btn;
        logic [7:0] hit;
        logic [7:0] sum;
        logic [7:0] chk;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
            btn = ($urandom_range(0, 9) < 7) ? 8'(BTN_SPEED_LO + $urandom_range(0, 7))
                                             : 8'($urandom_range(0, 255));
            hit = ($urandom_range(0, 4) < 3) ? CH_ONE : 8'($urandom_range(0, 255));
            sum = CH_START + CH_TYPE + btn + hit;
            chk = ~sum;
            if ($urandom_range(0, 9) == 0)
                chk = chk ^ 8'($urandom_range(1, 255));
            push_byte(CH_START, 1'b0, NO_REPORT);
            push_byte(CH_TYPE, 1'b0, NO_REPORT);
            push_byte(btn, 1'b0, NO_REPORT);
            push_byte(hit, 1'b0, NO_REPORT);
            push_byte(chk, 1'b0, NO_REPORT);
        end else if (pick < 82) begin
            // A start byte followed by anything but the type byte.
            btn = 8'($urandom_range(0, 255));
            if (btn == CH_TYPE)
                btn = CH_START;
            push_byte(CH_START, 1'b0, NO_REPORT);
            push_byte(btn, 1'b0, NO_REPORT);
        end else if (pick < 88) begin
            // A header and a button only; whatever follows is parsed as the rest.
            push_byte(CH_START, 1'b0, NO_REPORT);
            push_byte(CH_TYPE, 1'b0, NO_REPORT);
            push_byte(8'($urandom_range(0, 255)), 1'b0, NO_REPORT);
        end else begin
            push_byte(8'($urandom_range(0, 255)), 1'b0, NO_REPORT);
        end
    endtask

    // The receiver: stalls in bursts, as often as m_stall_pct asks.
    initial begin : receiver
        forever begin
            @(posedge aclk);
            if (m_stall_pct != 0 && $urandom_range(0, 99) < m_stall_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Result checker. An item moves at the rising edge that follows a falling edge at
    // which both m_tvalid and m_tready are high, and m_tdata cannot change in between.
    always @(negedge aclk) begin
        drive_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (drive_reports_due.size() == 0) begin
                $error("unexpected item on the master channel: m_tdata = %h", m_tdata);
                mismatch_count++;
            end else begin
                want = drive_reports_due.pop_front();
                if (m_tdata[7:0] !== want.button_code) begin
                    $error("button_code: expected %h, got %h", want.button_code,
                           m_tdata[7:0]);
                    mismatch_count++;
                end
                if (m_tdata[8] !== want.pressed) begin
                    $error("pressed: expected %b, got %b", want.pressed, m_tdata[8]);
                    mismatch_count++;
                end
                if (m_tdata[12:9] !== want.led_pattern) begin
                    $error("led_pattern: expected %h, got %h", want.led_pattern,
                           m_tdata[12:9]);
                    mismatch_count++;
                end
                if (m_tdata[16:13] !== want.left_drive) begin
                    $error("left_drive: expected %0d, got %0d", want.left_drive,
                           $signed(m_tdata[16:13]));
                    mismatch_count++;
                end
                if (m_tdata[20:17] !== want.right_drive) begin
                    $error("right_drive: expected %0d, got %0d", want.right_drive,
                           $signed(m_tdata[20:17]));
                    mismatch_count++;
                end
                if (m_tdata[23:21] !== 3'b000) begin
                    $error("padding: expected 0, got %b", m_tdata[23:21]);
                    mismatch_count++;
                end
            end
        end
    end

    // Guard against a hang.
    initial begin : watchdog
        #2_400_000;
        $display("button_packet_drive_decoder_core: mismatch");
        $finish;
    end

    initial begin : stimulus
        int seg;
        int last_seg;
        parse_phase = PH_IDLE;
        held_button = '0;
        held_hit    = '0;
        speed_step  = SPEED_RESET;
        left_cmd    = '0;
        right_cmd   = '0;
        last_seg    = -1;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, with light idling on both sides.
        s_gap_pct   = 20;
        m_stall_pct = 20;
        for (int i = 0; i < DIRECTED_N; i++)
            push_byte(directed_rows[i].rx_byte, directed_rows[i].typed,
                      directed_rows[i].want);

        // Hold the sender back until every report so far has come out.
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (drive_reports_due.size() != 0);

        // Random part. The idling mix is redrawn every 150 items or so, so there are
        // stretches of back-to-back traffic as well as heavy stalling; the tail of the
        // run has no idling at all.
        while (bytes_sent < DIRECTED_N + RANDOM_ITEMS) begin
            seg = bytes_sent / 150;
            if (bytes_sent >= DIRECTED_N + RANDOM_ITEMS - QUIET_TAIL) begin
                s_gap_pct   = 0;
                m_stall_pct = 0;
            end else if (seg != last_seg) begin
                last_seg = seg;
                case ($urandom_range(0, 2))
                    0: s_gap_pct = 0;
                    1: s_gap_pct = 15;
                    default: s_gap_pct = 40;
                endcase
                case ($urandom_range(0, 2))
                    0: m_stall_pct = 0;
                    1: m_stall_pct = 15;
                    default: m_stall_pct = 40;
                endcase
            end
            push_random_unit();
        end

        s_tvalid <= 1'b0;
        while (drive_reports_due.size() != 0)
            @(posedge aclk);
        // The block offers a result once the closing byte has moved from the input register
        // to the output register; waiting on afterwards shows any item that should not be there.
        repeat (10) @(posedge aclk);

        if (mismatch_count == 0)
            $display("button_packet_drive_decoder_core: match");
        else
            $display("button_packet_drive_decoder_core: mismatch");
        $finish;
    end

endmodule
